>>> rtl/cfcb_pkg.sv
// Shared types, constants and CRC step for the control frame checker.
package cfcb_pkg;

  localparam int unsigned CountW = 9;

  localparam logic [7:0]  CtrlType      = 8'h01;
  localparam logic [15:0] CrcPoly       = 16'hA001;
  localparam logic [8:0]  FirstHeader   = 9'd3;
  localparam logic [8:0]  MinAcceptLen  = 9'd5;
  localparam logic [8:0]  MinCrcLen     = 9'd3;
  localparam logic [8:0]  MinVersionLen = 9'd2;

  // Configuration register indexes
  localparam logic RegExpVersion   = 1'b0;
  localparam logic RegTargetBundle = 1'b1;

  typedef struct packed {
    logic [8:0] frame_length;
    logic       too_long;
    logic       crc_ok;
    logic       version_ok;
    logic [7:0] message_type;
    logic       accepted;
    logic       bundle_found;
    logic [7:0] bundle_length_byte;
    logic [8:0] payload_offset;
  } cfcb_result_t;

  // One byte of reflected CRC-16, bit at a time
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/cfcb_in_stage.sv
// Input register: holds one received word until the frame logic takes it.
module cfcb_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       advance,
  output logic       word_valid,
  output logic [7:0] word_data,
  output logic       word_last
);
  import cfcb_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       last_r;
  logic       load;

  assign in_stall = valid_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  assign word_valid = valid_r;
  assign word_data  = data_r;
  assign word_last  = last_r;
endmodule

>>> rtl/cfcb_frame.sv
// Per-frame state: CRC, byte count, header fields and bundle chain walk.
module cfcb_frame #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  logic [7:0]            word_data,
  input  logic                  word_last,
  input  logic [7:0]            expected_version,
  input  logic [7:0]            target_bundle,
  output cfcb_pkg::cfcb_result_t result
);
  import cfcb_pkg::*;

  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_FRAME);

  logic [15:0]       crc_r, crc_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [7:0]        d0_r, d0_nxt, d1_r, d1_nxt;
  logic [7:0]        ver_r, ver_nxt, type_r, type_nxt;
  logic [8:0]        nhp_r, nhp_nxt;
  logic [7:0]        hold_r, hold_nxt;
  logic              found_r, found_nxt;
  logic [7:0]        flen_r, flen_nxt;
  logic [8:0]        foff_r, foff_nxt;
  logic              ovf_r, ovf_nxt;

  logic              in_range;
  logic              at_header_id;
  logic              bf;

  always_comb begin
    in_range = count_r < MaxCount;
    crc_nxt  = crc_r;
    d0_nxt   = d0_r;
    d1_nxt   = d1_r;
    ver_nxt  = ver_r;
    type_nxt = type_r;
    nhp_nxt  = nhp_r;
    hold_nxt = hold_r;
    found_nxt = found_r;
    flen_nxt = flen_r;
    foff_nxt = foff_r;
    count_nxt = count_r;
    ovf_nxt  = ovf_r;
    at_header_id = ({1'b0, count_r} == ({1'b0, nhp_r} + 10'd1));

    if (in_range) begin
      if (count_r >= 9'd2) begin
        crc_nxt = crc_byte(crc_r, d0_r);
      end
      d0_nxt = d1_r;
      d1_nxt = word_data;
      if (count_r == 9'd0) begin
        type_nxt = word_data;
      end
      if (count_r == 9'd1) begin
        ver_nxt = word_data;
      end
      // Identifier byte of the current bundle header: match or hop on
      if (!found_r && at_header_id) begin
        if (word_data == target_bundle) begin
          found_nxt = 1'b1;
          flen_nxt  = hold_r;
          foff_nxt  = nhp_r + 9'd2;
        end else begin
          nhp_nxt = nhp_r + {1'b0, hold_r} + 9'd1;
        end
      end
      if (!found_nxt && count_r == nhp_nxt) begin
        hold_nxt = word_data;
      end
      count_nxt = count_r + 9'd1;
    end else begin
      ovf_nxt = 1'b1;
    end

    bf = !ovf_nxt && found_nxt && (foff_nxt < count_nxt);

    result.frame_length = count_nxt;
    result.too_long     = ovf_nxt;
    result.crc_ok       = !ovf_nxt && (count_nxt >= MinCrcLen)
                          && (crc_nxt == {d1_r, word_data});
    result.version_ok   = (count_nxt >= MinVersionLen) && (ver_nxt == expected_version);
    result.message_type = type_nxt;
    result.accepted     = result.crc_ok && result.version_ok && (type_nxt == CtrlType)
                          && (count_nxt > MinAcceptLen) && !ovf_nxt;
    result.bundle_found = bf;
    result.bundle_length_byte = bf ? flen_nxt : 8'd0;
    result.payload_offset     = bf ? foff_nxt : 9'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (advance && word_last)) begin
      crc_r   <= '0;
      count_r <= '0;
      d0_r    <= '0;
      d1_r    <= '0;
      ver_r   <= '0;
      type_r  <= '0;
      nhp_r   <= FirstHeader;
      hold_r  <= '0;
      found_r <= 1'b0;
      flen_r  <= '0;
      foff_r  <= '0;
      ovf_r   <= 1'b0;
    end else if (advance) begin
      crc_r   <= crc_nxt;
      count_r <= count_nxt;
      d0_r    <= d0_nxt;
      d1_r    <= d1_nxt;
      ver_r   <= ver_nxt;
      type_r  <= type_nxt;
      nhp_r   <= nhp_nxt;
      hold_r  <= hold_nxt;
      found_r <= found_nxt;
      flen_r  <= flen_nxt;
      foff_r  <= foff_nxt;
      ovf_r   <= ovf_nxt;
    end
  end
endmodule

>>> rtl/control_frame_checker_bundle_finder.sv
// Top level of the control frame checker with bundle finder.
//
// Usage: a received frame enters one word (byte) per handshake on the in_
// channel, in_last_byte high on its final word. Each word is checked on the
// fly: reflected CRC-16 over all but the last two words, compared with the
// trailing big-endian CRC; byte one against the expected version; byte zero
// as the message type; and the bundle chain from offset three is walked for
// the target bundle. One verdict word leaves on the out_ channel per frame,
// for the final word only; other words give nothing.
// The final word passes the input register, then the result register, whose
// output is the verdict. Throughput: one word per cycle while in_stall is
// low; the single-byte CRC step is the deepest logic per cycle.
// Stall: a verdict waiting on out_stall holds; non-final words keep flowing,
// and in_stall rises only when a final word meets a still-full result
// register. Reset clears all frame state, sets expected_version to 2 and
// target_bundle to 0. Configuration writes are taken at any edge with
// cfg_wr_en high and should only be made while no frame is in flight.
module control_frame_checker_bundle_finder #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [8:0] out_frame_length,
  output logic       out_too_long,
  output logic       out_crc_ok,
  output logic       out_version_ok,
  output logic [7:0] out_message_type,
  output logic       out_accepted,
  output logic       out_bundle_found,
  output logic [7:0] out_bundle_length_byte,
  output logic [8:0] out_payload_offset
);
  import cfcb_pkg::*;

  logic [7:0]   exp_version_r;
  logic [7:0]   target_r;
  logic         word_valid;
  logic [7:0]   word_data;
  logic         word_last;
  logic         advance;
  logic         out_valid_r, out_valid_nxt;
  cfcb_result_t result;
  cfcb_result_t result_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_version_r <= 8'd2;
      target_r      <= 8'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        RegExpVersion:   exp_version_r <= cfg_wr_data;
        RegTargetBundle: target_r      <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Advance a held word unless it is a final word and the verdict slot
  // stays occupied this cycle.
  assign advance = word_valid && (!word_last || !out_valid_r || !out_stall);

  cfcb_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .advance      (advance),
    .word_valid   (word_valid),
    .word_data    (word_data),
    .word_last    (word_last)
  );

  cfcb_frame #(
    .MAX_FRAME (MAX_FRAME)
  ) u_frame (
    .clk              (clk),
    .rst_n            (rst_n),
    .advance          (advance),
    .word_data        (word_data),
    .word_last        (word_last),
    .expected_version (exp_version_r),
    .target_bundle    (target_r),
    .result           (result)
  );

  // Result register: load on a final word, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && word_last) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && word_last) begin
      result_r <= result;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_frame_length       = result_r.frame_length;
  assign out_too_long           = result_r.too_long;
  assign out_crc_ok             = result_r.crc_ok;
  assign out_version_ok         = result_r.version_ok;
  assign out_message_type       = result_r.message_type;
  assign out_accepted           = result_r.accepted;
  assign out_bundle_found       = result_r.bundle_found;
  assign out_bundle_length_byte = result_r.bundle_length_byte;
  assign out_payload_offset     = result_r.payload_offset;
endmodule
